>>> hdl/pixel_peak_hit_accumulator_defines.svh
// assertion macros for the pixel peak hit accumulator checker
// expects signals clk and rst in the scope where a macro is used
`ifndef PIXEL_PEAK_HIT_ACCUMULATOR_DEFINES_SVH
`define PIXEL_PEAK_HIT_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define PPHA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define PPHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// what must hold in the cycle after reset
`define PPHA_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

>>> hdl/ppha_pkg.sv
// shared types and constants of the pixel peak hit accumulator
// no dependencies
package ppha_pkg;

  localparam logic [1:0] OP_PIXEL      = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_READ_CLEAR = 2'd2;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUM_MODE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PER_PIXEL    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_THR   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUM_OFFSET   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ROWS   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COLS   = 3'd6;

  // queue depth between front and back and of the result queue, power of two
  localparam int QUEUE_DEPTH = 4;
  // accumulator index field, wide enough for the largest store
  localparam int IDX_W = 24;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] pixel_value;
    logic [15:0] pixel_threshold;
    logic [15:0] read_address;
  } ppha_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  pixel_row;
    logic [7:0]  pixel_col;
    logic        hit;
    logic [31:0] accumulated;
  } ppha_out_t;

  typedef struct packed {
    logic        peak_mode;
    logic        sum_mode;
    logic        per_pixel_threshold;
    logic [15:0] global_threshold;
    logic [15:0] sum_offset;
    logic [8:0]  frame_rows;
    logic [8:0]  frame_cols;
  } ppha_cfg_t;

  // work handed from the front to the back
  typedef struct packed {
    logic             is_read;
    logic             clear;
    logic             hit;
    logic [7:0]       row;
    logic [7:0]       col;
    logic [IDX_W-1:0] idx;
    logic [31:0]      value;
  } ppha_cmd_t;

endpackage

>>> hdl/pixel_peak_hit_accumulator.sv
// pixel peak hit accumulator top level: configuration, clearing pass, queues
// depends on ppha_pkg, ppha_fifo, ppha_front, ppha_back
//
// Pixels enter in raster order through a queue-style push/full port and are
// tested either against a threshold alone or as a strict 3x3 local maximum
// above threshold (peak mode decides the pixel one row up and one column
// left, border pixels give no result). A hit bumps that pixel's 32-bit
// accumulator by one or by value minus offset; read and read-clear
// transactions return an entry. One transaction is taken per clock while
// full is low; a result reaches the result port through the decision stage,
// the front-to-back queue, the store read with one-entry write forwarding
// and the result queue. After reset the block runs a clearing pass over the
// accumulator store (MAX_ROWS*MAX_COLS entries, 65536 at the defaults)
// and the line store, holding full high meanwhile;
// configuration writes are taken at any time but should be made while idle.
module pixel_peak_hit_accumulator import ppha_pkg::*; #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int VALUE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ppha_in_t               item,
  output logic                   full,
  output logic                   empty,
  input  logic                   pop,
  output ppha_out_t              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);
  localparam int AW   = $clog2(MAX_ROWS*MAX_COLS);
  localparam int CNTW = $clog2(QUEUE_DEPTH+1);
  localparam int NW   = CNTW + 1;
  localparam int CMDW = $bits(ppha_cmd_t);
  localparam int OUTW = $bits(ppha_out_t);

  ppha_cfg_t     cfg;
  logic          clr_active;
  logic [AW-1:0] clr_addr;
  logic          accept;
  logic          front_busy;
  logic          cmd_valid;
  ppha_cmd_t     cmd;
  logic          mid_empty;
  logic [CNTW-1:0] mid_count;
  logic [CMDW-1:0] mid_rdata;
  logic          take;
  logic          res_valid;
  ppha_out_t     res;
  logic [CNTW-1:0] out_count;
  logic [OUTW-1:0] out_rdata;
  logic [NW-1:0] mid_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_mode           <= 1'b1;
      cfg.sum_mode            <= 1'b0;
      cfg.per_pixel_threshold <= 1'b0;
      cfg.global_threshold    <= '0;
      cfg.sum_offset          <= '0;
      cfg.frame_rows          <= 9'd256;
      cfg.frame_cols          <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PEAK_MODE:  cfg.peak_mode           <= cfg_data[0];
        CFG_SUM_MODE:   cfg.sum_mode            <= cfg_data[0];
        CFG_PER_PIXEL:  cfg.per_pixel_threshold <= cfg_data[0];
        CFG_GLOBAL_THR: cfg.global_threshold    <= cfg_data;
        CFG_SUM_OFFSET: cfg.sum_offset          <= cfg_data;
        CFG_FRAME_ROWS: cfg.frame_rows          <= cfg_data[8:0];
        CFG_FRAME_COLS: cfg.frame_cols          <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // clearing pass, one store entry per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (32'(clr_addr) == 32'(MAX_ROWS*MAX_COLS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // hold off input when the front-to-back queue could overflow
  assign mid_load = NW'(mid_count) + NW'(front_busy);
  assign full     = clr_active || (mid_load >= NW'(QUEUE_DEPTH));
  assign accept   = push && !full;

  ppha_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clr_active(clr_active),
    .clr_addr  (clr_addr),
    .accept    (accept),
    .item      (item),
    .busy      (front_busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // decouples classification from the store update
  ppha_fifo #(
    .WIDTH(CMDW),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_valid),
    .wdata(cmd),
    .pop  (take),
    .rdata(mid_rdata),
    .empty(mid_empty),
    .count(mid_count)
  );

  ppha_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clr_active(clr_active),
    .clr_addr  (clr_addr),
    .cmd_ready (!mid_empty),
    .cmd       (ppha_cmd_t'(mid_rdata)),
    .out_count (out_count),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue, the oldest result sits on the result port
  ppha_fifo #(
    .WIDTH(OUTW),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_valid),
    .wdata(res),
    .pop  (pop && !empty),
    .rdata(out_rdata),
    .empty(empty),
    .count(out_count)
  );

  assign result = ppha_out_t'(out_rdata);
endmodule

>>> hdl/ppha_fifo.sv
// small register queue used between front and back and for results
// depends on nothing; DEPTH must be a power of two
module ppha_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ($clog2(DEPTH+1))'(push) - ($clog2(DEPTH+1))'(pop);
    end
  end
endmodule

>>> hdl/ppha_front.sv
// front part: raster counters, line store, 3x3 window and hit decision
// depends on ppha_pkg
module ppha_front import ppha_pkg::*; #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int VALUE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ppha_cfg_t                              cfg,
  input  logic                                   clr_active,
  input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   clr_addr,
  input  logic                                   accept,
  input  ppha_in_t                               item,
  output logic                                   busy,
  output logic                                   cmd_valid,
  output ppha_cmd_t                              cmd
);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int VB = VALUE_BITS;

  typedef struct packed {
    logic [VB-1:0] v;
    logic [VB-1:0] t;
  } cell_t;

  typedef struct packed {
    cell_t up;
    cell_t mid;
  } line_t;

  logic [RW-1:0] row_cnt;
  logic [CW-1:0] col_cnt;
  logic [RW:0]   rows_eff;
  logic [CW:0]   cols_eff;
  logic [31:0]   rows_tmp;
  logic [31:0]   cols_tmp;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [VB+15:0] pv_ext;
  logic [VB+15:0] pt_ext;

  line_t         lmem [MAX_COLS];
  line_t         lrdata;
  line_t         lcur;
  logic          lfwd_valid;
  logic [CW-1:0] lfwd_addr;
  line_t         lfwd_data;

  logic          f1_valid;
  logic [1:0]    f1_op;
  cell_t         f1_cur;
  logic [RW-1:0] f1_r;
  logic [CW-1:0] f1_c;
  logic [15:0]   f1_addr;

  cell_t win [3][3];

  logic          is_pix;
  logic          is_rd;
  logic          decide;
  logic          hit;
  cell_t         ctr;
  logic [31:0]   thr;
  logic [RW-1:0] dr;
  logic [CW-1:0] dc;
  logic [RW+7:0] dr_ext;
  logic [CW+7:0] dc_ext;
  logic [31:0]   pix_idx;
  logic [31:0]   rd_idx;
  logic [31:0]   rd_r;
  logic [31:0]   rd_c;
  logic          rd_ok;

  assign busy = f1_valid;

  // frame size, out of range taken as the maximum
  always_comb begin
    rows_tmp = ((cfg.frame_rows == '0) || (32'(cfg.frame_rows) > 32'(MAX_ROWS)))
               ? 32'(MAX_ROWS) : 32'(cfg.frame_rows);
    cols_tmp = ((cfg.frame_cols == '0) || (32'(cfg.frame_cols) > 32'(MAX_COLS)))
               ? 32'(MAX_COLS) : 32'(cfg.frame_cols);
    rows_eff = rows_tmp[RW:0];
    cols_eff = cols_tmp[CW:0];
    col_inc  = {1'b0, col_cnt} + 1'b1;
    row_inc  = {1'b0, row_cnt} + 1'b1;
    pv_ext   = {{VB{1'b0}}, item.pixel_value};
    pt_ext   = {{VB{1'b0}}, item.pixel_threshold};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (accept && (item.opcode == OP_PIXEL)) begin
        if (col_inc >= cols_eff) begin
          col_cnt <= '0;
          row_cnt <= (row_inc >= rows_eff) ? '0 : row_inc[RW-1:0];
        end else begin
          col_cnt <= col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op    <= item.opcode;
      f1_cur.v <= pv_ext[VB-1:0];
      f1_cur.t <= pt_ext[VB-1:0];
      f1_r     <= row_cnt;
      f1_c     <= col_cnt;
      f1_addr  <= item.read_address;
      lrdata   <= lmem[col_cnt];
    end
  end

  // decision stage
  always_comb begin
    is_pix = f1_valid && (f1_op == OP_PIXEL);
    is_rd  = f1_valid && ((f1_op == OP_READ) || (f1_op == OP_READ_CLEAR));
    lcur   = (lfwd_valid && (lfwd_addr == f1_c)) ? lfwd_data : lrdata;
    if (cfg.peak_mode) begin
      decide = (32'(f1_r) >= 32'd2) && (32'(f1_c) >= 32'd2);
      ctr    = win[1][2];
      dr     = f1_r - 1'b1;
      dc     = f1_c - 1'b1;
    end else begin
      decide = 1'b1;
      ctr    = f1_cur;
      dr     = f1_r;
      dc     = f1_c;
    end
    thr = cfg.per_pixel_threshold ? 32'(ctr.t) : 32'(cfg.global_threshold);
    hit = (32'(ctr.v) > thr);
    if (cfg.peak_mode) begin
      // strict local maximum over the eight neighbours
      hit = hit && (ctr.v > win[0][1].v) && (ctr.v > win[0][2].v)
                && (ctr.v > win[1][1].v) && (ctr.v > win[2][1].v)
                && (ctr.v > win[2][2].v) && (ctr.v > lcur.up.v)
                && (ctr.v > lcur.mid.v) && (ctr.v > f1_cur.v);
    end
    dr_ext  = {8'b0, dr};
    dc_ext  = {8'b0, dc};
    pix_idx = 32'(dr) * 32'(MAX_COLS) + 32'(dc);
    rd_r    = 32'(f1_addr[15:8]);
    rd_c    = 32'(f1_addr[7:0]);
    rd_ok   = (rd_r < 32'(MAX_ROWS)) && (rd_c < 32'(MAX_COLS));
    rd_idx  = rd_r * 32'(MAX_COLS) + rd_c;

    cmd_valid = (is_pix && decide) || (is_rd && rd_ok);
    cmd.is_read = is_rd;
    cmd.clear   = (f1_op == OP_READ_CLEAR);
    cmd.hit     = is_pix && hit;
    cmd.row     = is_rd ? f1_addr[15:8] : dr_ext[7:0];
    cmd.col     = is_rd ? f1_addr[7:0] : dc_ext[7:0];
    cmd.idx     = is_rd ? rd_idx[IDX_W-1:0] : pix_idx[IDX_W-1:0];
    cmd.value   = 32'(ctr.v);
  end

  // window shift and line store update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (is_pix) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= lcur.up;
      win[1][2] <= lcur.mid;
      win[2][2] <= f1_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      if (32'(clr_addr) < 32'(MAX_COLS)) begin
        lmem[clr_addr[CW-1:0]] <= '0;
      end
    end else if (is_pix) begin
      lmem[f1_c] <= '{up: lcur.mid, mid: f1_cur};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfwd_valid <= 1'b0;
    end else if (is_pix) begin
      lfwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_pix) begin
      lfwd_addr <= f1_c;
      lfwd_data <= '{up: lcur.mid, mid: f1_cur};
    end
  end
endmodule

>>> hdl/ppha_back.sv
// back part: accumulator store read-modify-write and readout
// depends on ppha_pkg
module ppha_back import ppha_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ppha_cfg_t                            cfg,
  input  logic                                 clr_active,
  input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] clr_addr,
  input  logic                                 cmd_ready,
  input  ppha_cmd_t                            cmd,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_count,
  output logic                                 take,
  output logic                                 res_valid,
  output ppha_out_t                            res
);
  localparam int AW    = $clog2(MAX_ROWS*MAX_COLS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int NW    = $clog2(QUEUE_DEPTH+1) + 1;

  logic [31:0]   amem [DEPTH];
  logic [31:0]   rdata;
  logic          b_valid;
  ppha_cmd_t     b_cmd;
  logic          fwd_valid;
  logic [AW-1:0] fwd_idx;
  logic [31:0]   fwd_data;
  logic [31:0]   base;
  logic [31:0]   inc;
  logic [31:0]   sum;
  logic          we;
  logic [31:0]   wdata;
  logic [AW-1:0] b_idx;
  logic [NW-1:0] pending;

  // room left in the result queue, counting the item in flight
  assign pending = NW'(out_count) + NW'(b_valid);
  assign take    = cmd_ready && (pending < NW'(QUEUE_DEPTH));
  assign b_idx   = b_cmd.idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_cmd <= cmd;
      rdata <= amem[cmd.idx[AW-1:0]];
    end
  end

  always_comb begin
    base  = (fwd_valid && (fwd_idx == b_idx)) ? fwd_data : rdata;
    inc   = cfg.sum_mode ? (b_cmd.value - 32'(cfg.sum_offset)) : 32'd1;
    sum   = base + inc;
    we    = b_valid && (b_cmd.is_read ? b_cmd.clear : b_cmd.hit);
    wdata = b_cmd.is_read ? 32'd0 : sum;

    res_valid       = b_valid;
    res.result_kind = b_cmd.is_read ? KIND_READOUT : KIND_PIXEL;
    res.pixel_row   = b_cmd.row;
    res.pixel_col   = b_cmd.col;
    res.hit         = b_cmd.hit && !b_cmd.is_read;
    res.accumulated = (b_cmd.hit && !b_cmd.is_read) ? sum : base;
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      amem[clr_addr] <= '0;
    end else if (we) begin
      amem[b_idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_idx  <= b_idx;
      fwd_data <= wdata;
    end
  end
endmodule

>>> hdl/ppha_checker.sv
// port-level checker for the pixel peak hit accumulator, bound to the top
// depends on ppha_pkg and pixel_peak_hit_accumulator_defines.svh
`include "pixel_peak_hit_accumulator_defines.svh"

module ppha_port_checker import ppha_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input ppha_out_t result
);
  // the clearing pass blocks input right after reset
  `PPHA_ASSERT_AFTER_RESET(a_full_after_reset, full, "input not held off after reset")

  // no stale results survive reset
  `PPHA_ASSERT_AFTER_RESET(a_empty_after_reset, empty, "result shown right after reset")

  // readouts never report a hit
  `PPHA_ASSERT_IMPL(a_readout_no_hit, !empty && (result.result_kind == KIND_READOUT), !result.hit, "readout with hit set")

  // a waiting result holds until taken
  `PPHA_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result), "waiting result changed")
endmodule

bind pixel_peak_hit_accumulator ppha_port_checker u_ppha_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .result(result)
);
